@@ rtl/tns_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tns_pkg
// shared types, character codes and helpers of the text normaliser stream
// ----------------------------------------------------------------------------
package tns_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChPeriod = 8'h2E;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChExcl   = 8'h21;
  localparam logic [7:0] ChQuery  = 8'h3F;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChApos   = 8'h27;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] CaseBit  = 8'h20;

  // up to three filtered bytes from one request, before case folding
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } tns_entry_t;

  function automatic logic tns_is_mark(input logic [7:0] c);
    return (c == ChPeriod) || (c == ChComma) || (c == ChExcl) || (c == ChQuery) ||
           (c == ChSemi) || (c == ChColon) || (c == ChDash) || (c == ChApos) ||
           (c == ChQuote);
  endfunction

  function automatic logic tns_is_stop(input logic [7:0] c);
    return (c == ChPeriod) || (c == ChExcl) || (c == ChQuery);
  endfunction

endpackage
`default_nettype wire

@@ rtl/text_normalizer_stream_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_normalizer_stream_top
// streaming text normaliser: space collapsing, punctuation filter, sentence case
//
// input channel: push with char_in_i and is_last_i, taken when full is low;
// one byte of text per request, is_last_i on the final byte of a text.
// result channel: empty low means char_out_o, has_char_o and end_of_text_o hold
// the oldest result, taken when pop is high. a text with no output byte ends
// in a bare marker (has_char_o low, end_of_text_o high).
// the front takes one request per cycle while full is low and writes at most
// one entry of up to three bytes into a four-entry queue; the back delivers one
// result per cycle while pop is high or the output register is empty, from the
// queue into an output register. with nothing waiting, the first result of a
// request is written to the queue and then to the output register before it
// shows. requests are taken one per cycle while results average at most one per
// request; a request with three results holds the back until all three are out.
// a stalled receiver fills the output register, then the queue, then full rises.
// reset clears all text state; empty is high and full low afterwards.
// ----------------------------------------------------------------------------
module text_normalizer_stream_top import tns_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] char_in_i,
  input  wire logic       is_last_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      char_out_o,
  output logic            has_char_o,
  output logic            end_of_text_o
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  tns_entry_t q_wr_entry;
  tns_entry_t q_rd_entry;

  tns_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .char_in_i (char_in_i),
    .is_last_i (is_last_i),
    .q_push_o  (q_push),
    .q_entry_o (q_wr_entry),
    .q_full_i  (q_full)
  );

  tns_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .empty_o (q_empty)
  );

  tns_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (q_rd_entry),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .char_out_o    (char_out_o),
    .has_char_o    (has_char_o),
    .end_of_text_o (end_of_text_o)
  );

endmodule
`default_nettype wire

@@ rtl/tns_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tns_front
// space collapsing and punctuation filtering, one request per cycle while full is low
// ----------------------------------------------------------------------------
module tns_front import tns_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] char_in_i,
  input  wire logic       is_last_i,
  output logic            q_push_o,
  output tns_entry_t      q_entry_o,
  input  wire logic       q_full_i
);

  logic       acc;
  logic       sp_q, sp_d;
  logic       ne_q, ne_d;
  logic [1:0] cnt_q, cnt_d;
  logic       prev_q, prev_d;
  tns_entry_t ent;

  assign full = q_full_i;
  assign acc  = push & ~q_full_i;

  always_comb begin : p_step
    logic       pend;
    logic [1:0] n;
    pend       = sp_q;
    ne_d       = ne_q;
    cnt_d      = cnt_q;
    prev_d     = prev_q;
    n          = 2'd0;
    ent.bytes  = '0;
    ent.last   = is_last_i;
    if (char_in_i == ChSpace) begin
      if (ne_q) begin
        pend = 1'b1;
      end
    end else begin
      if (pend) begin
        if (cnt_d != 2'd0) begin
          if (!prev_d) begin
            ent.bytes[n] = ChPeriod;
            n            = n + 2'd1;
          end
          prev_d = 1'b1;
          cnt_d  = 2'd0;
        end
        ent.bytes[n] = ChSpace;
        n            = n + 2'd1;
        prev_d       = 1'b0;
        pend         = 1'b0;
      end
      if (char_in_i == ChPeriod) begin
        if (cnt_d == 2'd2) begin
          // ellipsis
          ent.bytes[0] = ChPeriod;
          ent.bytes[1] = ChPeriod;
          ent.bytes[2] = ChPeriod;
          n            = 2'd3;
          prev_d       = 1'b1;
          cnt_d        = 2'd0;
        end else begin
          cnt_d = cnt_d + 2'd1;
        end
      end else begin
        if (cnt_d != 2'd0) begin
          if (!prev_d) begin
            ent.bytes[n] = ChPeriod;
            n            = n + 2'd1;
          end
          prev_d = 1'b1;
          cnt_d  = 2'd0;
        end
        if (tns_is_mark(char_in_i)) begin
          if (!prev_d) begin
            ent.bytes[n] = char_in_i;
            n            = n + 2'd1;
            prev_d       = 1'b1;
          end
        end else begin
          ent.bytes[n] = char_in_i;
          n            = n + 2'd1;
          prev_d       = 1'b0;
        end
      end
      ne_d = 1'b1;
    end
    if (is_last_i) begin
      // flush held periods, then back to the start of a text
      if (cnt_d != 2'd0 && !prev_d) begin
        ent.bytes[n] = ChPeriod;
        n            = n + 2'd1;
      end
      pend   = 1'b0;
      ne_d   = 1'b0;
      cnt_d  = 2'd0;
      prev_d = 1'b0;
    end
    sp_d    = pend;
    ent.cnt = n;
  end

  assign q_entry_o = ent;
  assign q_push_o  = acc & ((ent.cnt != 2'd0) | is_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= 1'b0;
      ne_q   <= 1'b0;
      cnt_q  <= 2'd0;
      prev_q <= 1'b0;
    end else if (acc) begin
      sp_q   <= sp_d;
      ne_q   <= ne_d;
      cnt_q  <= cnt_d;
      prev_q <= prev_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tns_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tns_queue
// short queue of filtered entries between front and back
// ----------------------------------------------------------------------------
module tns_queue import tns_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  tns_entry_t      entry_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output tns_entry_t      entry_o,
  output logic            empty_o
);

  tns_entry_t           mem_q [QDepth];
  logic [QAw-1:0]       wr_q, wr_d;
  logic [QAw-1:0]       rd_q, rd_d;
  logic [QCw-1:0]       cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (cnt_q == QCw'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + QAw'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QAw'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCw'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCw'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tns_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tns_back
// unpacks queued entries one byte per cycle while pop is high or the output register is empty, applies sentence case
// ----------------------------------------------------------------------------
module tns_back import tns_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_empty_i,
  input  tns_entry_t      q_entry_i,
  output logic            q_pop_o,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      char_out_o,
  output logic            has_char_o,
  output logic            end_of_text_o
);

  logic       vld_q, vld_d;
  logic [7:0] chr_q;
  logic       has_q;
  logic       eot_q;
  logic [1:0] pos_q, pos_d;
  logic       ss_q, ss_d;
  logic       take;
  logic       fin;
  logic [7:0] raw;
  logic [7:0] chr;
  logic       ss_nx;

  assign take = (~vld_q | pop) & ~q_empty_i;
  assign raw  = q_entry_i.bytes[pos_q];
  assign fin  = (q_entry_i.cnt == 2'd0) || (pos_q == q_entry_i.cnt - 2'd1);

  always_comb begin
    chr   = raw;
    ss_nx = ss_q;
    if (raw inside {[ChUpperA:ChUpperZ]}) begin
      if (!ss_q) begin
        chr = raw | CaseBit;
      end
      ss_nx = 1'b0;
    end else if (raw inside {[ChLowerA:ChLowerZ]}) begin
      if (ss_q) begin
        chr = raw & ~CaseBit;
      end
      ss_nx = 1'b0;
    end else if (tns_is_stop(raw)) begin
      ss_nx = 1'b1;
    end
    if (q_entry_i.cnt == 2'd0) begin
      chr = 8'h00;
    end
  end

  always_comb begin
    vld_d = take | (vld_q & ~pop);
    pos_d = pos_q;
    ss_d  = ss_q;
    if (take) begin
      pos_d = fin ? 2'd0 : pos_q + 2'd1;
      ss_d  = (fin & q_entry_i.last) ? 1'b1 : ss_nx;
    end
  end

  assign q_pop_o       = take & fin;
  assign empty         = ~vld_q;
  assign char_out_o    = chr_q;
  assign has_char_o    = has_q;
  assign end_of_text_o = eot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      pos_q <= 2'd0;
      ss_q  <= 1'b1;
    end else begin
      vld_q <= vld_d;
      pos_q <= pos_d;
      ss_q  <= ss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      chr_q <= chr;
      has_q <= (q_entry_i.cnt != 2'd0);
      eot_q <= fin & q_entry_i.last;
    end
  end

endmodule
`default_nettype wire

@@ test/tb_text_normalizer_stream_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_normalizer_stream_top
// self-checking bench for the streaming text normaliser
//
// texts are sent one byte per request: a short directed set first, then mostly
// well-formed random sentences and some random-byte noise. an in-bench model of
// the three stages (space collapsing, punctuation filter, sentence case)
// predicts each result, and every popped result is checked field by field in
// order. both sides idle at random; once the receiver holds off long enough for
// full to rise.
// ----------------------------------------------------------------------------
module tb_text_normalizer_stream_top import tns_pkg::*;;

  localparam int unsigned ClkHalf      = 6;
  localparam int unsigned ResetCycles  = 11;
  localparam int unsigned RandomItems  = 450;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned TailCycles   = 12;
  localparam int unsigned HoldCycles   = 150;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned MaxStepBytes = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       eot;
  } norm_res_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] char_in_i;
  logic       is_last_i;
  logic       empty;
  logic       pop;
  logic [7:0] char_out_o;
  logic       has_char_o;
  logic       end_of_text_o;

  text_normalizer_stream_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .char_in_i     (char_in_i),
    .is_last_i     (is_last_i),
    .empty         (empty),
    .pop           (pop),
    .char_out_o    (char_out_o),
    .has_char_o    (has_char_o),
    .end_of_text_o (end_of_text_o)
  );

  text_req_t   text_q[$];
  norm_res_t   norm_out_q[$];
  logic [7:0]  step_bytes[$];

  // normaliser state
  logic        nm_space_pend;
  logic        nm_text_begun;
  logic        nm_prev_punct;
  logic        nm_sent_start;
  int unsigned nm_dots;

  int unsigned n_reqs;
  int unsigned n_texts;
  int unsigned n_results;
  int unsigned n_bare;
  int unsigned n_ellipsis;
  int unsigned n_full_cycles;
  int unsigned n_mismatch;
  int unsigned idle_cnt;

  bit          req_taken;
  bit          res_taken;
  bit          send_calm;
  bit          recv_calm;
  bit          hold_done;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_cnt;

  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  function automatic void clear_text_state();
    nm_space_pend = 1'b0;
    nm_text_begun = 1'b0;
    nm_prev_punct = 1'b0;
    nm_sent_start = 1'b1;
    nm_dots       = 0;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    case (c)
      ChPeriod, ChComma, ChExcl, ChQuery, ChSemi,
      ChColon, ChDash, ChApos, ChQuote: return 1'b1;
      default:                          return 1'b0;
    endcase
  endfunction

  function automatic void case_stage(input logic [7:0] c);
    logic [7:0] o;
    logic       up;
    logic       lo;
    o  = c;
    up = (c >= ChUpperA) && (c <= ChUpperZ);
    lo = (c >= ChLowerA) && (c <= ChLowerZ);
    if (up || lo) begin
      if (nm_sent_start) begin
        if (lo) o = c - CaseBit;
        nm_sent_start = 1'b0;
      end else if (up) begin
        o = c + CaseBit;
      end
    end else if (c == ChPeriod || c == ChExcl || c == ChQuery) begin
      nm_sent_start = 1'b1;
    end
    if (step_bytes.size() < MaxStepBytes) step_bytes.insert(step_bytes.size(), o);
  endfunction

  function automatic void punct_stage(input logic [7:0] c);
    if (is_punct(c)) begin
      if (!nm_prev_punct) begin
        case_stage(c);
        nm_prev_punct = 1'b1;
      end
    end else begin
      case_stage(c);
      nm_prev_punct = 1'b0;
    end
  endfunction

  function automatic void flush_dots();
    repeat (nm_dots) punct_stage(ChPeriod);
    nm_dots = 0;
  endfunction

  function automatic void filter_stage(input logic [7:0] c);
    if (c == ChPeriod) begin
      if (nm_dots >= 2) begin
        repeat (3) case_stage(ChPeriod);
        nm_prev_punct = 1'b1;
        nm_dots       = 0;
        n_ellipsis++;
      end else begin
        nm_dots++;
      end
    end else begin
      flush_dots();
      punct_stage(c);
    end
  endfunction

  function automatic void normalise_byte(input logic [7:0] c, input logic last);
    norm_res_t r;
    step_bytes.delete();
    if (c == ChSpace) begin
      if (nm_text_begun) nm_space_pend = 1'b1;
    end else begin
      if (nm_space_pend) begin
        filter_stage(ChSpace);
        nm_space_pend = 1'b0;
      end
      filter_stage(c);
      nm_text_begun = 1'b1;
    end
    if (last) begin
      flush_dots();
      nm_space_pend = 1'b0;
    end
    foreach (step_bytes[i]) begin
      r.ch  = step_bytes[i];
      r.has = 1'b1;
      r.eot = last && (i == step_bytes.size() - 1);
      norm_out_q.insert(norm_out_q.size(), r);
    end
    if (last) begin
      if (step_bytes.size() == 0) begin
        r.ch  = 8'h00;
        r.has = 1'b0;
        r.eot = 1'b1;
        norm_out_q.insert(norm_out_q.size(), r);
        n_bare++;
      end
      clear_text_state();
    end
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  task automatic add_req(input logic [7:0] c, input logic last);
    text_req_t t;
    t.ch   = c;
    t.last = last;
    text_q.insert(text_q.size(), t);
  endtask

  task automatic add_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) add_req(s[i], ends && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] sentence_byte();
    logic [7:0] marks [9];
    int unsigned r;
    marks = '{ChPeriod, ChComma, ChExcl, ChQuery, ChSemi,
              ChColon, ChDash, ChApos, ChQuote};
    r = $urandom_range(0, 99);
    if (r < 20) return ChLowerA + 8'($urandom_range(0, 25));
    if (r < 38) return ChUpperA + 8'($urandom_range(0, 25));
    if (r < 62) return ChSpace;
    if (r < 78) return ChPeriod;
    if (r < 92) return marks[$urandom_range(0, 8)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_random_texts();
    int unsigned total;
    int unsigned len;
    bit          noise;
    total = 0;
    while (total < RandomItems) begin
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                          : $urandom_range(1, 16);
      noise = ($urandom_range(0, 99) < 15);
      for (int i = 0; i < len; i++) begin
        add_req(noise ? 8'($urandom_range(0, 255)) : sentence_byte(), i == len - 1);
      end
      total += len;
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (req_taken) begin
      req_taken = 1'b0;
      if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
      send_gap = pick_gap(send_calm);
    end
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (send_gap > 0) begin
      push <= 1'b0;
      send_gap--;
    end else if (text_q.size() > 0) begin
      push      <= 1'b1;
      char_in_i <= text_q[0].ch;
      is_last_i <= text_q[0].last;
    end else begin
      push <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (res_taken) begin
      res_taken = 1'b0;
      if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
      recv_gap = pick_gap(recv_calm);
      if (!hold_done && n_results >= 120) begin
        hold_done = 1'b1;
        hold_cnt  = HoldCycles;
      end
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      pop <= 1'b0;
      hold_cnt--;
    end else if (recv_gap > 0) begin
      pop <= 1'b0;
      recv_gap--;
    end else begin
      pop <= 1'b1;
    end
  end

  // acceptance, prediction and checking
  always @(posedge clk_i) begin
    norm_res_t got;
    norm_res_t want;
    if (rst_ni) begin
      if (full) n_full_cycles++;
      if (push && !full) begin
        normalise_byte(char_in_i, is_last_i);
        text_q.delete(0);
        req_taken = 1'b1;
        n_reqs++;
        if (is_last_i) n_texts++;
      end
      if (pop && !empty) begin
        got = {char_out_o, has_char_o, end_of_text_o};
        res_taken = 1'b1;
        n_results++;
        if (norm_out_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MaxReports)
            $display("unexpected result: ch %02h has %0b eot %0b", got.ch, got.has, got.eot);
        end else begin
          want = norm_out_q.pop_front();
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= MaxReports)
              $display({"mismatch on result %0d: exp ch %02h has %0b eot %0b, ",
                        "got ch %02h has %0b eot %0b"},
                       n_results, want.ch, want.has, want.eot, got.ch, got.has, got.eot);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IdleLimit) begin
        $display("timeout: no request or result moved for %0d cycles", IdleLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni    = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    char_in_i = 8'h00;
    is_last_i = 1'b0;
    clear_text_state();

    add_text(" ", 1'b1);
    add_text(",", 1'b1);
    add_text("..", 1'b1);
    add_text("  hI  ,...Zz", 1'b0);
    add_req(8'hFF, 1'b0);
    add_req(8'h00, 1'b0);
    add_text("?! ", 1'b1);
    add_text(".. b", 1'b1);
    add_random_texts();

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (text_q.size() > 0 || norm_out_q.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d requests in %0d texts: %0d results checked, %0d bare end markers",
             n_reqs, n_texts, n_results, n_bare);
    $display("%0d ellipses seen, input stalled by a full queue for %0d cycles",
             n_ellipsis, n_full_cycles);
    if (n_mismatch == 0 && norm_out_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", n_mismatch, norm_out_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
